/* rtl/core/blph_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blph_pkg
// Shared codes and controller/datapath interface types for the hash table.
// ----------------------------------------------------------------------------
package blph_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] ST_NEW  = 3'd0;
  localparam logic [2:0] ST_HIT  = 3'd1;
  localparam logic [2:0] ST_MISS = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO = 3'd4;

  typedef enum logic [1:0] {
    KS_IN,
    KS_ZERO,
    KS_RD
  } ksrc_e;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       rd;
    logic       kwe;
    ksrc_e      kw_src;
    logic       kw_at_freed;
    logic       vwe;
    logic       vw_src_rd;
    logic       vw_at_freed;
    logic       adv;
    logic       set_freed;
    logic       res_set;
    logic [2:0] res_status;
    logic       res_rd;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       key_zero;
    logic       k_empty;
    logic       k_match;
    logic       home_match;
    logic       find_more;
    logic       shift_more;
  } stat_t;

endpackage

/* rtl/core/blph_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blph_datapath
// Slot memories, probe pointer, operand and result registers.
// ----------------------------------------------------------------------------
module blph_datapath #(
  parameter int TABLE_LOG2  = 10,
  parameter int PROBE_LIMIT = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  blph_pkg::cmd_t  cmd_i,
  output blph_pkg::stat_t stat_o,
  input  logic [1:0]      op_i,
  input  logic [63:0]     key_i,
  input  logic [63:0]     value_i,
  output logic [2:0]      status_o,
  output logic [63:0]     value_out_o
);

  localparam int Slots = 1 << TABLE_LOG2;
  localparam int PW    = $clog2(PROBE_LIMIT + 1);

  logic [63:0] key_mem [Slots];
  logic [63:0] val_mem [Slots];

  logic [TABLE_LOG2-1:0] clr_q, idx_q, freed_q;
  logic [PW-1:0]         p_q;
  logic [1:0]            op_q;
  logic [63:0]           key_q, val_q, key_rd_q, val_rd_q;
  logic [2:0]            status_q;
  logic [63:0]           res_q;

  logic [TABLE_LOG2-1:0] kaddr, vaddr;
  logic [63:0]           kdata, vdata;
  logic                  kwe;

  always_comb begin
    kwe   = cmd_i.kwe | cmd_i.clr;
    kaddr = cmd_i.clr ? clr_q : (cmd_i.kw_at_freed ? freed_q : idx_q);
    case (cmd_i.kw_src)
      blph_pkg::KS_IN: kdata = key_q;
      blph_pkg::KS_RD: kdata = key_rd_q;
      default:         kdata = '0;
    endcase
    if (cmd_i.clr) kdata = '0;
    vaddr = cmd_i.vw_at_freed ? freed_q : idx_q;
    vdata = cmd_i.vw_src_rd ? val_rd_q : val_q;
  end

  always_ff @(posedge clk_i) begin
    if (kwe) key_mem[kaddr] <= kdata;
    if (cmd_i.vwe) val_mem[vaddr] <= vdata;
    if (cmd_i.rd) begin
      key_rd_q <= key_mem[idx_q];
      val_rd_q <= val_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      key_q <= key_i;
      val_q <= value_i;
      idx_q <= key_i[TABLE_LOG2-1:0];
      p_q   <= '0;
    end else if (cmd_i.adv) begin
      idx_q <= idx_q + 1'b1;
      p_q   <= p_q + 1'b1;
    end
    if (cmd_i.set_freed) freed_q <= idx_q;
    if (cmd_i.res_set) begin
      status_q <= cmd_i.res_status;
      res_q    <= cmd_i.res_rd ? val_rd_q : '0;
    end
  end

  always_comb begin
    stat_o.clr_last   = &clr_q;
    stat_o.op         = op_q;
    stat_o.key_zero   = (key_q == '0);
    stat_o.k_empty    = (key_rd_q == '0);
    stat_o.k_match    = (key_rd_q == key_q);
    stat_o.home_match = (key_rd_q[TABLE_LOG2-1:0] == key_q[TABLE_LOG2-1:0]);
    stat_o.find_more  = !(&idx_q) && (p_q < PW'(PROBE_LIMIT - 1));
    stat_o.shift_more = !(&idx_q) && (p_q < PW'(PROBE_LIMIT));
  end

  assign status_o    = status_q;
  assign value_out_o = res_q;

endmodule

/* rtl/core/blph_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blph_ctrl
// Sequencer for clear pass, probe walk and remove back-shift.
// ----------------------------------------------------------------------------
module blph_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output logic            valid_o,
  output blph_pkg::cmd_t  cmd_o,
  input  blph_pkg::stat_t stat_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_WIPE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       shift_q, shift_d;
  logic       valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    cmd_o.kw_src = blph_pkg::KS_ZERO;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          shift_d = 1'b0;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.op != blph_pkg::OP_INSERT && stat_i.op != blph_pkg::OP_LOOKUP &&
            stat_i.op != blph_pkg::OP_REMOVE) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_status = blph_pkg::ST_MISS;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.key_zero) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_status = blph_pkg::ST_ZERO;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (shift_q) begin
          if (stat_i.k_empty) begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end else if (stat_i.home_match) begin
            cmd_o.kwe = 1'b1;
            cmd_o.kw_src = blph_pkg::KS_RD;
            cmd_o.kw_at_freed = 1'b1;
            cmd_o.vwe = 1'b1;
            cmd_o.vw_src_rd = 1'b1;
            cmd_o.vw_at_freed = 1'b1;
            state_d = S_WIPE;
          end else if (stat_i.shift_more) begin
            cmd_o.adv = 1'b1;
            state_d = S_READ;
          end else begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          case (stat_i.op) inside
            blph_pkg::OP_INSERT: begin
              if (stat_i.k_empty) begin
                cmd_o.kwe = 1'b1;
                cmd_o.kw_src = blph_pkg::KS_IN;
                cmd_o.vwe = 1'b1;
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = blph_pkg::ST_NEW;
                valid_d = 1'b1;
                state_d = S_IDLE;
              end else if (stat_i.k_match) begin
                cmd_o.vwe = 1'b1;
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = blph_pkg::ST_HIT;
                cmd_o.res_rd = 1'b1;
                valid_d = 1'b1;
                state_d = S_IDLE;
              end else if (stat_i.find_more) begin
                cmd_o.adv = 1'b1;
                state_d = S_READ;
              end else begin
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = blph_pkg::ST_FULL;
                valid_d = 1'b1;
                state_d = S_IDLE;
              end
            end
            blph_pkg::OP_LOOKUP, blph_pkg::OP_REMOVE: begin
              if (stat_i.k_match) begin
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = blph_pkg::ST_HIT;
                cmd_o.res_rd = 1'b1;
                if (stat_i.op == blph_pkg::OP_REMOVE) begin
                  cmd_o.kwe = 1'b1;
                  cmd_o.set_freed = 1'b1;
                  shift_d = 1'b1;
                  if (stat_i.shift_more) begin
                    cmd_o.adv = 1'b1;
                    state_d = S_READ;
                  end else begin
                    valid_d = 1'b1;
                    state_d = S_IDLE;
                  end
                end else begin
                  valid_d = 1'b1;
                  state_d = S_IDLE;
                end
              end else if (stat_i.find_more) begin
                cmd_o.adv = 1'b1;
                state_d = S_READ;
              end else begin
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = blph_pkg::ST_MISS;
                valid_d = 1'b1;
                state_d = S_IDLE;
              end
            end
            default: begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_status = blph_pkg::ST_MISS;
              valid_d = 1'b1;
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_WIPE: begin
        cmd_o.kwe = 1'b1;
        cmd_o.set_freed = 1'b1;
        if (stat_i.shift_more) begin
          cmd_o.adv = 1'b1;
          state_d = S_READ;
        end else begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      shift_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      shift_q <= shift_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;

endmodule

/* rtl/core/bounded_linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_linear_probe_hash_table
// Key/value table with bounded, non-wrapping linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op_i, key_i, value_i and raise start_i; the beat is taken at a
//   rising edge where busy_o is low. One result beat per command appears on
//   status_o / value_out_o for exactly one cycle with valid_o high; the
//   receiver cannot stall it.
// Sequence:
//   Each probed slot takes a registered memory read, then a check.
//   Zero key or unused op: answered from the evaluate step, no slot read.
//   Lookup/insert: up to PROBE_LIMIT slots probed. Remove adds a wipe step
//   per entry moved back. busy_o stays high until the result beat is issued.
// Reset:
//   After rst_ni releases, the key store is swept one slot per cycle over
//   all 2**TABLE_LOG2 slots, with busy_o high.
// ----------------------------------------------------------------------------
module bounded_linear_probe_hash_table #(
  parameter int TABLE_LOG2  = 10,
  parameter int PROBE_LIMIT = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [63:0] value_out_o
);

  blph_pkg::cmd_t  cmd;
  blph_pkg::stat_t stat;

  blph_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  blph_datapath #(
    .TABLE_LOG2  (TABLE_LOG2),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (op_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .status_o    (status_o),
    .value_out_o (value_out_o)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded linear-probe hash table.
// Commands are sent through the start/busy handshake and each one is scored
// against an in-bench table model. The expected status and value go into a
// queue, and every valid_o beat is compared with the oldest entry. Directed
// cases cover zero keys, the unused op, full chains, the end of the table,
// holes and duplicate keys. Random traffic then runs on colliding key pools
// under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS     = 1024;
  localparam int PROBE_MAX = 5;
  localparam int CYCLE_CAP = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] value;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  op_i = blph_pkg::OP_LOOKUP;
  logic [63:0] key_i = '0;
  logic [63:0] value_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [63:0] value_out_o;

  bit [63:0] key_tab [SLOTS];
  bit [63:0] val_tab [SLOTS];
  answer_t   answers_due [$];
  int        errors = 0;
  int        sent = 0;
  int        checked = 0;
  int        cycles = 0;
  int        idle_pct = 0;
  bit [63:0] pool [32];

  bounded_linear_probe_hash_table DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .op_i       (op_i),
    .key_i      (key_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .value_out_o(value_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout at %0t", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int home_slot(bit [63:0] k);
    return int'(k[9:0]);
  endfunction

  function automatic bit [63:0] mk_key(int home);
    bit [63:0] k;
    k = {$urandom, $urandom};
    k[9:0] = home[9:0];
    if (k == 0) k[63] = 1'b1;
    return k;
  endfunction

  function automatic answer_t table_apply(logic [1:0] op, bit [63:0] k, bit [63:0] v);
    answer_t a;
    int idx, p, freed, h;
    bit found;
    a.status = blph_pkg::ST_MISS;
    a.value  = '0;
    h = home_slot(k);
    if (op == OP_UNUSED) return a;
    if (k == 0) begin
      a.status = blph_pkg::ST_ZERO;
      return a;
    end
    if (op == blph_pkg::OP_INSERT) begin
      a.status = blph_pkg::ST_FULL;
      for (int i = h; i < SLOTS && i - h < PROBE_MAX; i++) begin
        if (key_tab[i] == 0) begin
          key_tab[i] = k;
          val_tab[i] = v;
          a.status = blph_pkg::ST_NEW;
          break;
        end
        if (key_tab[i] == k) begin
          a.value = val_tab[i];
          val_tab[i] = v;
          a.status = blph_pkg::ST_HIT;
          break;
        end
      end
      return a;
    end
    found = 1'b0;
    idx = h;
    p = 0;
    while (idx < SLOTS && p < PROBE_MAX) begin
      if (key_tab[idx] == k) begin
        found = 1'b1;
        break;
      end
      idx++;
      p++;
    end
    if (!found) return a;
    a.status = blph_pkg::ST_HIT;
    a.value = val_tab[idx];
    if (op != blph_pkg::OP_REMOVE) return a;
    key_tab[idx] = '0;
    val_tab[idx] = '0;
    freed = idx;
    while (idx + 1 < SLOTS && p < PROBE_MAX) begin
      idx++;
      p++;
      if (key_tab[idx] == 0) break;
      if (home_slot(key_tab[idx]) == h) begin
        key_tab[freed] = key_tab[idx];
        val_tab[freed] = val_tab[idx];
        key_tab[idx] = '0;
        val_tab[idx] = '0;
        freed = idx;
      end
    end
    return a;
  endfunction

  task automatic send_cmd(logic [1:0] op, bit [63:0] k, bit [63:0] v);
    start_i <= 1'b1;
    op_i    <= op;
    key_i   <= k;
    value_i <= v;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    answers_due.push_back(table_apply(op, k, v));
    sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected beat status=%0d value=%h", $time, status_o, value_out_o);
        errors++;
      end else begin
        answer_t a;
        a = answers_due.pop_front();
        checked++;
        if (status_o !== a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, a.status, status_o);
          errors++;
        end
        if (value_out_o !== a.value) begin
          $display("%0t: value expected %h actual %h", $time, a.value, value_out_o);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    start_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic test_zero_and_unused();
    send_cmd(blph_pkg::OP_INSERT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(blph_pkg::OP_LOOKUP, 64'd0, 64'd0);
    send_cmd(blph_pkg::OP_REMOVE, 64'd0, 64'd0);
    send_cmd(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
    send_cmd(OP_UNUSED, 64'd0, 64'd0);
  endtask

  task automatic test_chains();
    bit [63:0] k [6];
    bit [63:0] d0, d1, dk;
    for (int i = 0; i < 6; i++) k[i] = mk_key(100);
    send_cmd(blph_pkg::OP_LOOKUP, k[0], 64'd0);
    for (int i = 0; i < 6; i++) send_cmd(blph_pkg::OP_INSERT, k[i], {$urandom, $urandom});
    send_cmd(blph_pkg::OP_INSERT, k[2], 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(blph_pkg::OP_LOOKUP, k[4], 64'd0);
    send_cmd(blph_pkg::OP_REMOVE, k[1], 64'd0);
    send_cmd(blph_pkg::OP_LOOKUP, k[4], 64'd0);
    send_cmd(blph_pkg::OP_REMOVE, k[1], 64'd0);
    send_cmd(blph_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_cmd(blph_pkg::OP_INSERT, mk_key(1023), 64'd5);
    send_cmd(blph_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    d0 = mk_key(299);
    d1 = mk_key(299);
    dk = mk_key(300);
    send_cmd(blph_pkg::OP_INSERT, d0, 64'd1);
    send_cmd(blph_pkg::OP_INSERT, d1, 64'd2);
    send_cmd(blph_pkg::OP_INSERT, dk, 64'd3);
    send_cmd(blph_pkg::OP_REMOVE, d1, 64'd0);
    send_cmd(blph_pkg::OP_INSERT, dk, 64'd4);
    send_cmd(blph_pkg::OP_LOOKUP, dk, 64'd0);
    send_cmd(blph_pkg::OP_REMOVE, dk, 64'd0);
    send_cmd(blph_pkg::OP_LOOKUP, dk, 64'd0);
  endtask

  task automatic test_random(int n, int pct);
    int base;
    idle_pct = pct;
    base = ($urandom_range(1) == 1) ? 1016 : $urandom_range(8, 1000);
    for (int i = 0; i < 32; i++) pool[i] = mk_key(base + $urandom_range(0, 7) - 4);
    for (int i = 0; i < n; i++) begin
      logic [1:0] op;
      bit [63:0] k;
      int r;
      r = $urandom_range(99);
      op = (r < 45) ? blph_pkg::OP_INSERT : (r < 75) ? blph_pkg::OP_LOOKUP :
           (r < 97) ? blph_pkg::OP_REMOVE : OP_UNUSED;
      r = $urandom_range(99);
      k = (r < 85) ? pool[$urandom_range(31)] : (r < 92) ? mk_key($urandom_range(1023)) :
          (r < 96) ? 64'd0 : {$urandom, $urandom};
      send_cmd(op, k, {$urandom, $urandom});
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_zero_and_unused();
    test_chains();
    drain();
    test_random(110, 0);
    test_random(110, 60);
    test_random(110, 0);
    test_random(110, 33);
    $display("Sent %0d commands, scored %0d result beats across four idle phases.", sent, checked);
    $display("Covered zero keys, unused op, full chains, table end, holes and duplicates.");
    if (errors == 0 && answers_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/blph_pkg.sv
rtl/core/blph_datapath.sv
rtl/core/blph_ctrl.sv
rtl/core/bounded_linear_probe_hash_table.sv
tb/tb_top.sv
